// ----- design/diff_drive_mixer_slew_limiter_macros.svh -----
// Assertion macros used by the port-level checker of the drive mixer.
`ifndef DIFF_DRIVE_MIXER_SLEW_LIMITER_MACROS_SVH
`define DIFF_DRIVE_MIXER_SLEW_LIMITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DDMSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DDMSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ddmsl_pkg.sv -----
// Shared constants of the differential drive mixer with slew limit.
`default_nettype none

package ddmsl_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_SCALE_LINEAR  = 3'd0;
   localparam logic [2:0] REG_SCALE_ANGULAR = 3'd1;
   localparam logic [2:0] REG_MAX_VELOCITY  = 3'd2;
   localparam logic [2:0] REG_MAX_CHANGE    = 3'd3;
   localparam logic [2:0] REG_MIN_VELOCITY  = 3'd4;
   localparam logic [2:0] REG_CONTROL_MODE  = 3'd5;

   // Register reset values
   localparam logic [15:0] RST_SCALE_LINEAR  = 16'd32768;
   localparam logic [15:0] RST_SCALE_ANGULAR = 16'd32768;
   localparam logic [14:0] RST_MAX_VELOCITY  = 15'd5120;
   localparam logic [14:0] RST_MAX_CHANGE    = 15'd128;
   localparam logic [14:0] RST_MIN_VELOCITY  = 15'd26;
   localparam logic [1:0]  RST_CONTROL_MODE  = 2'd0;

   // Control modes
   localparam logic [1:0] MODE_ACTIONS = 2'd2;

   // Control codes
   localparam logic [1:0] CODE_VELOCITY   = 2'd0;
   localparam logic [1:0] CODE_ENERGY     = 2'd1;
   localparam logic [1:0] CODE_CIRCLE     = 2'd2;
   localparam logic [1:0] CODE_LEMNISCATE = 2'd3;

endpackage

`default_nettype wire

// ----- design/diff_drive_mixer_slew_limiter.sv -----
// Top level: joystick arcade mixer for a differential drive with slew limit.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  axes Q1.15, four buttons
//   rsp      out        rsp_valid/rsp_ready  drive/control command, Q8.8 speeds
//   csr      in         csr_write_enable     index, 16-bit data
//
// A drive request runs through six sequencer steps around one shared 34x17
// multiplier (two gain products, two mixing products), with rounding/clamp and
// slew shaping overlapped on later steps. The next request can be taken while
// that result is shown, if the receiver takes it. Stop and control-code requests
// are answered in the cycle after acceptance; an arming request gives no answer.
// Synchronous reset clears state and prior velocities; registers get reset values.
// A request is taken only while idle and the result register is free or draining.
`default_nettype none

module diff_drive_mixer_slew_limiter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_throttle_axis,
   input  wire logic signed [15:0] req_turn_axis,
   input  wire logic               req_deadman_held,
   input  wire logic               req_energy_button,
   input  wire logic               req_circle_button,
   input  wire logic               req_lemniscate_button,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_drive_valid,
   output logic                    rsp_drive_mode,
   output logic signed [15:0]      rsp_left_velocity,
   output logic signed [15:0]      rsp_right_velocity,
   output logic                    rsp_control_valid,
   output logic [1:0]              rsp_control_code,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_write_data
);
   import ddmsl_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_MUL_T   = 7'b0000010,
      ST_MUL_R   = 7'b0000100,
      ST_MUL_L   = 7'b0001000,
      ST_MUL_RR  = 7'b0010000,
      ST_SHAPE_L = 7'b0100000,
      ST_SHAPE_R = 7'b1000000
   } state_type;

   // Round vmax*d/2^31 half away from zero, clamp to +-vmax
   function automatic logic signed [15:0] mix_side(input logic signed [48:0] p,
                                                   input logic [14:0] vmax);
      logic        neg;
      logic [48:0] mag;
      logic [48:0] sum;
      logic [17:0] q;
      logic [14:0] qc;
      logic [15:0] v;
      neg = p[48];
      mag = neg ? 49'(-p) : 49'(p);
      sum = mag + (49'd1 << 30);
      q   = sum[48:31];
      qc  = (q > {3'b000, vmax}) ? vmax : q[14:0];
      v   = {1'b0, qc};
      return neg ? $signed(-v) : $signed(v);
   endfunction

   // Limit the step against prev, then raise small magnitudes to minv
   function automatic logic signed [15:0] shape_side(input logic signed [15:0] v,
                                                     input logic signed [15:0] prev,
                                                     input logic [14:0] mc,
                                                     input logic [14:0] minv);
      logic signed [17:0] lo;
      logic signed [17:0] hi;
      logic signed [17:0] w;
      logic signed [17:0] wm;
      logic signed [17:0] mn;
      lo = $signed({{2{prev[15]}}, prev}) - $signed({3'b000, mc});
      hi = $signed({{2{prev[15]}}, prev}) + $signed({3'b000, mc});
      mn = $signed({3'b000, minv});
      w  = $signed({{2{v[15]}}, v});
      if (w < lo) begin
         w = lo;
      end else if (w > hi) begin
         w = hi;
      end
      wm = w[17] ? -w : w;
      if (wm < mn) begin
         w = w[17] ? -mn : mn;
      end
      return w[15:0];
   endfunction

   state_type          state_ff, state_in;
   logic               armed_ff, armed_in;
   logic signed [15:0] prev_left_ff, prev_left_in;
   logic signed [15:0] prev_right_ff, prev_right_in;

   logic [15:0] scale_linear_ff;
   logic [15:0] scale_angular_ff;
   logic [14:0] max_velocity_ff;
   logic [14:0] max_change_ff;
   logic [14:0] min_velocity_ff;
   logic [1:0]  control_mode_ff;

   logic signed [15:0] ax_ff, ax_in;
   logic signed [15:0] ay_ff, ay_in;
   logic signed [32:0] t_ff, t_in;
   logic signed [32:0] r_ff, r_in;
   logic signed [48:0] p_ff, p_in;
   logic signed [15:0] q_ff, q_in;
   logic signed [15:0] left_ff, left_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               drive_valid_ff, drive_valid_in;
   logic               drive_mode_ff, drive_mode_in;
   logic signed [15:0] out_left_ff, out_left_in;
   logic signed [15:0] out_right_ff, out_right_in;
   logic               control_valid_ff, control_valid_in;
   logic [1:0]         control_code_ff, control_code_in;

   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] mul_p;
   logic signed [33:0] diff_tr;
   logic signed [33:0] sum_tr;
   logic               accept;
   logic               any_button;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign any_button = req_energy_button || req_circle_button || req_lemniscate_button;

   assign diff_tr = $signed({t_ff[32], t_ff}) - $signed({r_ff[32], r_ff});
   assign sum_tr  = $signed({t_ff[32], t_ff}) + $signed({r_ff[32], r_ff});

   // Select the operands of the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_MUL_T: begin
            mul_a = 34'(ax_ff);
            mul_b = $signed({1'b0, scale_linear_ff});
         end
         ST_MUL_R: begin
            mul_a = 34'(ay_ff);
            mul_b = $signed({1'b0, scale_angular_ff});
         end
         ST_MUL_L: begin
            mul_a = diff_tr;
            mul_b = $signed({2'b00, max_velocity_ff});
         end
         ST_MUL_RR: begin
            mul_a = sum_tr;
            mul_b = $signed({2'b00, max_velocity_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Sequence a request through the shared multiplier
   always_comb begin
      state_in         = state_ff;
      armed_in         = armed_ff;
      prev_left_in     = prev_left_ff;
      prev_right_in    = prev_right_ff;
      ax_in            = ax_ff;
      ay_in            = ay_ff;
      t_in             = t_ff;
      r_in             = r_ff;
      p_in             = p_ff;
      q_in             = q_ff;
      left_in          = left_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      drive_valid_in   = drive_valid_ff;
      drive_mode_in    = drive_mode_ff;
      out_left_in      = out_left_ff;
      out_right_in     = out_right_ff;
      control_valid_in = control_valid_ff;
      control_code_in  = control_code_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!armed_ff) begin
                  armed_in = 1'b1;
               end else if (!req_deadman_held) begin
                  // stop command
                  rsp_valid_in     = 1'b1;
                  drive_valid_in   = 1'b1;
                  drive_mode_in    = 1'b0;
                  out_left_in      = '0;
                  out_right_in     = '0;
                  control_valid_in = 1'b0;
                  control_code_in  = CODE_VELOCITY;
               end else if (control_mode_ff == MODE_ACTIONS && any_button) begin
                  // action button, energy first
                  rsp_valid_in     = 1'b1;
                  drive_valid_in   = 1'b0;
                  drive_mode_in    = 1'b0;
                  out_left_in      = '0;
                  out_right_in     = '0;
                  control_valid_in = 1'b1;
                  control_code_in  = req_energy_button ? CODE_ENERGY :
                                     (req_circle_button ? CODE_CIRCLE : CODE_LEMNISCATE);
               end else begin
                  ax_in    = req_throttle_axis;
                  ay_in    = req_turn_axis;
                  state_in = ST_MUL_T;
               end
            end
         end
         ST_MUL_T: begin
            t_in     = mul_p[32:0];
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            r_in     = mul_p[32:0];
            state_in = ST_MUL_L;
         end
         ST_MUL_L: begin
            p_in     = mul_p[48:0];
            state_in = ST_MUL_RR;
         end
         ST_MUL_RR: begin
            q_in     = mix_side(p_ff, max_velocity_ff);
            p_in     = mul_p[48:0];
            state_in = ST_SHAPE_L;
         end
         ST_SHAPE_L: begin
            left_in  = shape_side(q_ff, prev_left_ff, max_change_ff, min_velocity_ff);
            q_in     = mix_side(p_ff, max_velocity_ff);
            state_in = ST_SHAPE_R;
         end
         ST_SHAPE_R: begin
            // drive command; the result register is free here
            out_right_in     = shape_side(q_ff, prev_right_ff, max_change_ff,
                                          min_velocity_ff);
            out_left_in      = left_ff;
            prev_left_in     = left_ff;
            prev_right_in    = out_right_in;
            rsp_valid_in     = 1'b1;
            drive_valid_in   = 1'b1;
            drive_mode_in    = 1'b1;
            control_valid_in = 1'b1;
            control_code_in  = CODE_VELOCITY;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         armed_ff      <= 1'b0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         armed_ff      <= armed_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath and result payload
   always_ff @(posedge clock) begin
      ax_ff            <= ax_in;
      ay_ff            <= ay_in;
      t_ff             <= t_in;
      r_ff             <= r_in;
      p_ff             <= p_in;
      q_ff             <= q_in;
      left_ff          <= left_in;
      drive_valid_ff   <= drive_valid_in;
      drive_mode_ff    <= drive_mode_in;
      out_left_ff      <= out_left_in;
      out_right_ff     <= out_right_in;
      control_valid_ff <= control_valid_in;
      control_code_ff  <= control_code_in;
   end

   // Decode configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_linear_ff  <= RST_SCALE_LINEAR;
         scale_angular_ff <= RST_SCALE_ANGULAR;
         max_velocity_ff  <= RST_MAX_VELOCITY;
         max_change_ff    <= RST_MAX_CHANGE;
         min_velocity_ff  <= RST_MIN_VELOCITY;
         control_mode_ff  <= RST_CONTROL_MODE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_SCALE_LINEAR:  scale_linear_ff  <= csr_write_data;
            REG_SCALE_ANGULAR: scale_angular_ff <= csr_write_data;
            REG_MAX_VELOCITY:  max_velocity_ff  <= csr_write_data[14:0];
            REG_MAX_CHANGE:    max_change_ff    <= csr_write_data[14:0];
            REG_MIN_VELOCITY:  min_velocity_ff  <= csr_write_data[14:0];
            REG_CONTROL_MODE:  control_mode_ff  <= csr_write_data[1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_valid    = drive_valid_ff;
   assign rsp_drive_mode     = drive_mode_ff;
   assign rsp_left_velocity  = out_left_ff;
   assign rsp_right_velocity = out_right_ff;
   assign rsp_control_valid  = control_valid_ff;
   assign rsp_control_code   = control_code_ff;

endmodule

`default_nettype wire

// ----- design/ddmsl_checker.sv -----
// Port-level checker of the drive mixer, bound to the top level.
`default_nettype none

`include "diff_drive_mixer_slew_limiter_macros.svh"

module ddmsl_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_drive_valid,
   input wire logic               rsp_drive_mode,
   input wire logic signed [15:0] rsp_left_velocity,
   input wire logic signed [15:0] rsp_right_velocity,
   input wire logic               rsp_control_valid,
   input wire logic [1:0]         rsp_control_code
);
   import ddmsl_pkg::*;

   // Hold a stalled result on the result side
   `DDMSL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_drive_valid, rsp_drive_mode, rsp_left_velocity, rsp_right_velocity, rsp_control_valid, rsp_control_code}), "result changed while stalled")

   // No new request while a result is stuck
   `DDMSL_ASSERT_NOW(a_no_take_when_full, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken with result register full")

   // Control codes carry no drive
   `DDMSL_ASSERT_NOW(a_code_no_drive, clock, reset, rsp_valid && rsp_control_code != CODE_VELOCITY, rsp_control_valid && !rsp_drive_valid && !rsp_drive_mode && rsp_left_velocity == 16'sd0 && rsp_right_velocity == 16'sd0, "control code result carries drive")

   // Stop commands are zero speed without a code
   `DDMSL_ASSERT_NOW(a_stop_zero, clock, reset, rsp_valid && rsp_drive_valid && !rsp_drive_mode, !rsp_control_valid && rsp_left_velocity == 16'sd0 && rsp_right_velocity == 16'sd0, "stop result not zero")

endmodule

bind diff_drive_mixer_slew_limiter ddmsl_checker u_ddmsl_checker (.*);

`default_nettype wire

// ----- tb/ddmsl_cmd_checker.sv -----
// Checker for the drive mixer: watches all ports, predicts each command and compares it.
module ddmsl_cmd_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [15:0] req_throttle_axis,
   input  wire logic signed [15:0] req_turn_axis,
   input  wire logic               req_deadman_held,
   input  wire logic               req_energy_button,
   input  wire logic               req_circle_button,
   input  wire logic               req_lemniscate_button,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               rsp_drive_valid,
   input  wire logic               rsp_drive_mode,
   input  wire logic signed [15:0] rsp_left_velocity,
   input  wire logic signed [15:0] rsp_right_velocity,
   input  wire logic               rsp_control_valid,
   input  wire logic [1:0]         rsp_control_code,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_write_data,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ddmsl_pkg::*;

   typedef struct packed {
      logic               drive_valid;
      logic               drive_mode;
      logic signed [15:0] left_velocity;
      logic signed [15:0] right_velocity;
      logic               control_valid;
      logic [1:0]         control_code;
   } wheel_cmd_type;

   // Shadow copy of the registers
   int         gain_lin;
   int         gain_ang;
   int         vel_limit;
   int         step_limit;
   int         vel_floor;
   logic [1:0] mode_sel;

   // Shadow copy of the mixer state
   bit armed;
   int prior_left;
   int prior_right;

   wheel_cmd_type cmd_queue[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Scale a mixed sum by the velocity limit back to Q8.8, round half away, clamp
   function automatic int mix_wheel(input longint sum);
      longint prod;
      longint mag;
      longint q;
      prod = longint'(vel_limit) * sum;
      mag  = (prod < 0) ? -prod : prod;
      q    = (mag + (longint'(1) << 30)) >>> 31;
      if (prod < 0) q = -q;
      if (q > vel_limit) q = vel_limit;
      if (q < -vel_limit) q = -vel_limit;
      return int'(q);
   endfunction

   // Hold the step within the slew limit, then lift small speeds to the floor
   function automatic int shape_wheel(input int v, input int prev);
      int lo;
      int hi;
      int mag;
      lo = prev - step_limit;
      hi = prev + step_limit;
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      mag = (v < 0) ? -v : v;
      if (mag < vel_floor) v = (v < 0) ? -vel_floor : vel_floor;
      return v;
   endfunction

   // Advance the shadow state by one sample; return 1 when a command follows
   function automatic bit predict_cmd(input logic signed [15:0] thr,
                                      input logic signed [15:0] turn,
                                      input logic dm, input logic en,
                                      input logic ci, input logic le,
                                      output wheel_cmd_type cmd);
      longint t;
      longint r;
      int     left;
      int     right;
      cmd = '0;
      if (!armed) begin
         armed = 1'b1;
         return 1'b0;
      end
      if (!dm) begin
         cmd.drive_valid = 1'b1;
         return 1'b1;
      end
      if (mode_sel == MODE_ACTIONS && (en || ci || le)) begin
         cmd.control_valid = 1'b1;
         cmd.control_code  = en ? CODE_ENERGY : (ci ? CODE_CIRCLE : CODE_LEMNISCATE);
         return 1'b1;
      end
      t     = longint'(thr) * longint'(gain_lin);
      r     = longint'(turn) * longint'(gain_ang);
      left  = shape_wheel(mix_wheel(t - r), prior_left);
      right = shape_wheel(mix_wheel(t + r), prior_right);
      prior_left  = left;
      prior_right = right;
      cmd.drive_valid    = 1'b1;
      cmd.drive_mode     = 1'b1;
      cmd.left_velocity  = left[15:0];
      cmd.right_velocity = right[15:0];
      cmd.control_valid  = 1'b1;
      cmd.control_code   = CODE_VELOCITY;
      return 1'b1;
   endfunction

   // Count a fault, print the first few
   task automatic log_fault(input string what, input wheel_cmd_type want,
                            input wheel_cmd_type got);
      fail_count = fail_count + 1;
      if (fail_count <= 10)
         $display("%0t %s: expected dv=%0d dm=%0d l=%0d r=%0d cv=%0d cc=%0d, got dv=%0d dm=%0d l=%0d r=%0d cv=%0d cc=%0d",
                  $realtime, what, want.drive_valid, want.drive_mode, want.left_velocity,
                  want.right_velocity, want.control_valid, want.control_code, got.drive_valid,
                  got.drive_mode, got.left_velocity, got.right_velocity, got.control_valid,
                  got.control_code);
   endtask

   always @(posedge clock) begin : watch
      wheel_cmd_type got;
      wheel_cmd_type want;
      wheel_cmd_type fresh;
      if (reset) begin
         gain_lin    = int'(RST_SCALE_LINEAR);
         gain_ang    = int'(RST_SCALE_ANGULAR);
         vel_limit   = int'(RST_MAX_VELOCITY);
         step_limit  = int'(RST_MAX_CHANGE);
         vel_floor   = int'(RST_MIN_VELOCITY);
         mode_sel    = RST_CONTROL_MODE;
         armed       = 1'b0;
         prior_left  = 0;
         prior_right = 0;
         cmd_queue.delete();
      end else begin
         // Track register writes
         if (csr_write_enable) begin
            case (csr_index)
               REG_SCALE_LINEAR:  gain_lin   = int'(csr_write_data);
               REG_SCALE_ANGULAR: gain_ang   = int'(csr_write_data);
               REG_MAX_VELOCITY:  vel_limit  = int'(csr_write_data[14:0]);
               REG_MAX_CHANGE:    step_limit = int'(csr_write_data[14:0]);
               REG_MIN_VELOCITY:  vel_floor  = int'(csr_write_data[14:0]);
               REG_CONTROL_MODE:  mode_sel   = csr_write_data[1:0];
               default: ;
            endcase
         end
         // Compare an accepted command against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.drive_valid    = rsp_drive_valid;
            got.drive_mode     = rsp_drive_mode;
            got.left_velocity  = rsp_left_velocity;
            got.right_velocity = rsp_right_velocity;
            got.control_valid  = rsp_control_valid;
            got.control_code   = rsp_control_code;
            if (cmd_queue.size() == 0) begin
               log_fault("command with no request pending", '0, got);
            end else begin
               want = cmd_queue.pop_front();
               if (got !== want) log_fault("command mismatch", want, got);
            end
         end
         // Predict the command of an accepted request
         if (req_valid && req_ready) begin
            if (predict_cmd(req_throttle_axis, req_turn_axis, req_deadman_held,
                            req_energy_button, req_circle_button, req_lemniscate_button,
                            fresh))
               cmd_queue.push_back(fresh);
         end
      end
      pending = cmd_queue.size();
   end

endmodule

// ----- tb/diff_drive_mixer_slew_limiter_tb.sv -----
// Testbench top for the drive mixer: clock, reset, stimulus phases and the verdict.
module diff_drive_mixer_slew_limiter_tb;
   import ddmsl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_SETPOINT = 2'd1;
   localparam int PHASES          = 16;
   localparam int ITEMS_PER_PHASE = 103;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_throttle_axis;
   logic signed [15:0] req_turn_axis;
   logic               req_deadman_held;
   logic               req_energy_button;
   logic               req_circle_button;
   logic               req_lemniscate_button;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_drive_valid;
   logic               rsp_drive_mode;
   logic signed [15:0] rsp_left_velocity;
   logic signed [15:0] rsp_right_velocity;
   logic               rsp_control_valid;
   logic [1:0]         rsp_control_code;
   logic               csr_write_enable;
   logic [2:0]         csr_index;
   logic [15:0]        csr_write_data;

   int fail_count;
   int pending;
   int idle_pct;
   int stall_pct;

   diff_drive_mixer_slew_limiter u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_throttle_axis     (req_throttle_axis),
      .req_turn_axis         (req_turn_axis),
      .req_deadman_held      (req_deadman_held),
      .req_energy_button     (req_energy_button),
      .req_circle_button     (req_circle_button),
      .req_lemniscate_button (req_lemniscate_button),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_drive_valid       (rsp_drive_valid),
      .rsp_drive_mode        (rsp_drive_mode),
      .rsp_left_velocity     (rsp_left_velocity),
      .rsp_right_velocity    (rsp_right_velocity),
      .rsp_control_valid     (rsp_control_valid),
      .rsp_control_code      (rsp_control_code),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   ddmsl_cmd_checker u_cmd_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_throttle_axis     (req_throttle_axis),
      .req_turn_axis         (req_turn_axis),
      .req_deadman_held      (req_deadman_held),
      .req_energy_button     (req_energy_button),
      .req_circle_button     (req_circle_button),
      .req_lemniscate_button (req_lemniscate_button),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_drive_valid       (rsp_drive_valid),
      .rsp_drive_mode        (rsp_drive_mode),
      .rsp_left_velocity     (rsp_left_velocity),
      .rsp_right_velocity    (rsp_right_velocity),
      .rsp_control_valid     (rsp_control_valid),
      .rsp_control_code      (rsp_control_code),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .fail_count            (fail_count),
      .pending               (pending)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: stall at the current rate, change only on the falling edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("diff_drive_mixer_slew_limiter regression: fail");
      $finish;
   end

   // Offer one request after a random gap, hold it until accepted
   task automatic send_sample(input logic signed [15:0] thr, input logic signed [15:0] turn,
                              input logic dm, input logic en, input logic ci, input logic le);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid             = 1'b1;
      req_throttle_axis     = thr;
      req_turn_axis         = turn;
      req_deadman_held      = dm;
      req_energy_button     = en;
      req_circle_button     = ci;
      req_lemniscate_button = le;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted command, then let the block go quiet
   task automatic settle();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [15:0] sl, input logic [15:0] sa,
                               input logic [15:0] vmax, input logic [15:0] mc,
                               input logic [15:0] vmin, input logic [1:0] mode);
      write_reg(REG_SCALE_LINEAR, sl);
      write_reg(REG_SCALE_ANGULAR, sa);
      write_reg(REG_MAX_VELOCITY, vmax);
      write_reg(REG_MAX_CHANGE, mc);
      write_reg(REG_MIN_VELOCITY, vmin);
      write_reg(REG_CONTROL_MODE, {14'd0, mode});
      csr_write_enable = 1'b0;
   endtask

   // Axis value biased toward the ends and toward zero
   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(5))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($signed($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic [15:0] sl;
      logic [15:0] sa;
      logic [15:0] vmax;
      logic [15:0] mc;
      logic [15:0] vmin;
      logic [1:0]  mode;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_throttle_axis     = '0;
      req_turn_axis         = '0;
      req_deadman_held      = 1'b0;
      req_energy_button     = 1'b0;
      req_circle_button     = 1'b0;
      req_lemniscate_button = 1'b0;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      idle_pct              = 0;
      stall_pct             = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: arming sample, axis extremes, zero speed, stop, ignored buttons
      send_sample(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(16'sh7FFF, 16'sh0000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(16'sh8000, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(16'sh0000, 16'sh0000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(16'sh4000, 16'shC000, 1'b1, 1'b1, 1'b1, 1'b1);

      // Action buttons: priority order, deadman over buttons, unlimited slew
      settle();
      apply_config(16'd32768, 16'd32768, 16'd5120, 16'd32767, 16'd0, MODE_ACTIONS);
      send_sample(16'sh1234, 16'sh4321, 1'b1, 1'b1, 1'b1, 1'b1);
      send_sample(16'sh1234, 16'sh4321, 1'b1, 1'b0, 1'b1, 1'b1);
      send_sample(16'sh1234, 16'sh4321, 1'b1, 1'b0, 1'b0, 1'b1);
      send_sample(16'sh1234, 16'sh4321, 1'b0, 1'b1, 1'b0, 1'b0);
      send_sample(16'sh7FFF, 16'sh0000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(16'sh0001, 16'shFFFF, 1'b1, 1'b0, 1'b0, 1'b0);

      // Full gains and limits, frozen slew, floor at the top
      settle();
      apply_config(16'hFFFF, 16'hFFFF, 16'd32767, 16'd0, 16'd32767, MODE_SETPOINT);
      send_sample(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 1'b0, 1'b0);
      send_sample(16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b1, 1'b0);
      send_sample(16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0, 1'b1);
      send_sample(16'sh0000, 16'sh0000, 1'b1, 1'b0, 1'b0, 1'b0);

      // Random phases, each with its own settings, idling and stalling
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case ($urandom_range(3))
            0:       sl = 16'd0;
            1:       sl = 16'hFFFF;
            default: sl = 16'($urandom);
         endcase
         case ($urandom_range(3))
            0:       sa = 16'd0;
            1:       sa = 16'hFFFF;
            default: sa = 16'($urandom);
         endcase
         case ($urandom_range(4))
            0:       vmax = 16'd0;
            1:       vmax = 16'd32767;
            2:       vmax = 16'($urandom_range(8192, 256));
            default: vmax = 16'($urandom_range(32767));
         endcase
         case ($urandom_range(4))
            0:       mc = 16'd0;
            1:       mc = 16'd32767;
            2, 3:    mc = 16'($urandom_range(600, 1));
            default: mc = 16'($urandom_range(32767));
         endcase
         case ($urandom_range(4))
            0:       vmin = 16'd0;
            1:       vmin = 16'd32767;
            2, 3:    vmin = 16'($urandom_range(80));
            default: vmin = 16'($urandom_range(32767));
         endcase
         mode = 2'($urandom_range(2));
         apply_config(sl, sa, vmax, mc, vmin, mode);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_sample(rand_axis(), rand_axis(), $urandom_range(99) >= 15,
                        $urandom_range(99) < 12, $urandom_range(99) < 12,
                        $urandom_range(99) < 12);
         idle_pct  = 0;
         stall_pct = 0;
      end

      // Drain and give the verdict
      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("diff_drive_mixer_slew_limiter regression: pass");
      end else begin
         $display("diff_drive_mixer_slew_limiter regression: fail");
      end
      $finish;
   end

endmodule
